// File: rtl/irsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irsc_pkg: shared types and codes of the junction record table
// record layout, command and status codes, key and merge helpers
// ----------------------------------------------------------------------------
package irsc_pkg;

	typedef enum logic [1:0] {
		CMD_APPEND   = 2'd0,
		CMD_COALESCE = 2'd1,
		CMD_READ     = 2'd2,
		CMD_CLEAR    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_RANGE = 2'd2
	} status_t;

	localparam logic [1:0] STRAND_UNKNOWN = 2'd2;
	localparam int KEY_W = 72;

	typedef struct packed {
		logic [9:0]  chrom;
		logic [30:0] start_pos;
		logic [30:0] end_pos;
		logic [31:0] support;
		logic [23:0] uniq;
		logic [23:0] secondary;
		logic [1:0]  strand;
		logic [15:0] samples;
		logic [15:0] edit;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	function automatic logic [KEY_W-1:0] rec_key(input rec_t r);
		rec_key = {r.chrom, r.start_pos, r.end_pos};
	endfunction

	function automatic logic [31:0] sat32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		sat32 = s[32] ? '1 : s[31:0];
	endfunction

	function automatic logic [23:0] sat24(input logic [23:0] a, input logic [23:0] b);
		logic [24:0] s;
		s = {1'b0, a} + {1'b0, b};
		sat24 = s[24] ? '1 : s[23:0];
	endfunction

	function automatic logic [15:0] sat16(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		sat16 = s[16] ? '1 : s[15:0];
	endfunction

	// fold a later record with an equal key into the first one
	function automatic rec_t merge_rec(input rec_t a, input rec_t b);
		rec_t m;
		m = a;
		m.support   = sat32(a.support, b.support);
		m.uniq      = sat24(a.uniq, b.uniq);
		m.secondary = sat24(a.secondary, b.secondary);
		m.samples   = sat16(a.samples, b.samples);
		if (a.strand == STRAND_UNKNOWN) begin
			m.strand = b.strand;
		end
		merge_rec = m;
	endfunction

endpackage
`default_nettype wire

// File: rtl/irsc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irsc_ram: generic simple dual port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module irsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: rtl/interval_record_sort_coalesce.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// interval_record_sort_coalesce: junction record table with sort and merge
// holds up to TABLE_DEPTH records and sorts and merges them by key on command
// ----------------------------------------------------------------------------
// One input word carries a command and gives exactly one result word. Append,
// clear and an out-of-range read go from idle straight to the finish state;
// an in-range read first passes a read wait state. The finish state loads the
// output register once it is free. Coalesce runs a stable bottom-up merge sort
// between two record banks and then one in-place reduce pass. Each merge step
// compares and writes, then refills the consumed head through the registered
// bank read port. Each block also loads both heads before its first step and
// is closed after its last. The reduce pass reads each record in turn and
// folds it or writes the run before it. Coalesce time is set by the shared
// read address of the record banks and the key comparators. The block takes
// no word until the current one is done; a finished result waits in the output
// register.
// Support is unsigned Q24.8; all sums saturate at their field maximum.
// ----------------------------------------------------------------------------
module interval_record_sort_coalesce #(
	parameter int TABLE_DEPTH = 1024
) (
	input  wire          clk,
	input  wire          arst_n,
	// slave side
	input  wire          s_tvalid,
	output logic         s_tready,
	// chrom_id, start_pos, end_pos, support_in, unique_in, secondary_in,
	// strand_in, samples_in, edit_in, entry_index, zero fill
	input  wire [199:0]  s_tdata,
	// cmd
	input  wire [1:0]    s_tuser,
	// master side
	output logic         m_tvalid,
	input  wire          m_tready,
	// entry_count, chrom_out, start_out, end_out, support_out, unique_out,
	// secondary_out, strand_out, samples_out, edit_out, zero fill
	output logic [199:0] m_tdata,
	// status
	output logic [1:0]   m_tuser
);
	import irsc_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int PW = CW + 2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RWAIT, ST_BLK, ST_FL, ST_FLW, ST_FR, ST_FRW, ST_MERGE,
		ST_RD0, ST_RD0W, ST_RLOOP, ST_RW, ST_FIN
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  count_q;
	logic           home_q;     // bank holding the live table
	logic           src_q;      // bank read during sort and reduce
	logic           both_q;     // refill both heads at block start
	logic [PW-1:0]  w_q, lo_q, mid_q, hi_q, l_q, r_q, o_q;
	logic [CW-1:0]  i_q, k_q;
	rec_t           left_q, right_q, acc_q, res_rec_q;
	status_t        res_status_q;

	// unpack input word
	rec_t           in_rec;
	cmd_t           in_cmd;
	logic [9:0]     in_index;
	assign in_rec.chrom     = s_tdata[9:0];
	assign in_rec.start_pos = s_tdata[40:10];
	assign in_rec.end_pos   = s_tdata[71:41];
	assign in_rec.support   = s_tdata[103:72];
	assign in_rec.uniq      = s_tdata[127:104];
	assign in_rec.secondary = s_tdata[151:128];
	assign in_rec.strand    = s_tdata[153:152];
	assign in_rec.samples   = s_tdata[169:154];
	assign in_rec.edit      = s_tdata[185:170];
	assign in_index         = s_tdata[195:186];
	assign in_cmd           = cmd_t'(s_tuser);

	wire accept = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);

	// record banks, ping-pong during sort
	logic           wr_en, wr_bank;
	logic [AW-1:0]  wr_addr, rd_addr;
	rec_t           wr_data, rd_data;
	logic [REC_W-1:0] rd0, rd1;

	irsc_ram #(.WIDTH(REC_W), .DEPTH(TABLE_DEPTH)) u_bank0 (
		.clk(clk), .we(wr_en && !wr_bank), .waddr(wr_addr), .wdata(wr_data),
		.raddr(rd_addr), .rdata(rd0)
	);
	irsc_ram #(.WIDTH(REC_W), .DEPTH(TABLE_DEPTH)) u_bank1 (
		.clk(clk), .we(wr_en && wr_bank), .waddr(wr_addr), .wdata(wr_data),
		.raddr(rd_addr), .rdata(rd1)
	);

	// read data comes from the live bank for a read command, else the sort source
	wire rd_bank = (state_q == ST_RWAIT) ? home_q : src_q;
	assign rd_data = rec_t'(rd_bank ? rd1 : rd0);

	wire [PW-1:0] n_p     = PW'(count_q);
	wire          full    = (count_q >= CW'(TABLE_DEPTH));
	wire          out_rng = (32'(in_index) >= 32'(count_q));
	wire          l_has   = (l_q < mid_q);
	wire          r_has   = (r_q < hi_q);
	// stable: right head wins only when strictly smaller
	wire          take_r  = r_has && (!l_has || (rec_key(right_q) < rec_key(left_q)));
	wire          key_eq  = (rec_key(rd_data) == rec_key(acc_q));
	wire [PW-1:0] blk_m   = ((lo_q + w_q) < n_p) ? (lo_q + w_q) : n_p;
	wire [PW-1:0] blk_h   = ((lo_q + (w_q << 1)) < n_p) ? (lo_q + (w_q << 1)) : n_p;
	wire [PW-1:0] nxt_lo  = lo_q + (w_q << 1);
	wire          slot_free = !m_tvalid || m_tready;

	// bank port steering
	always_comb begin
		wr_en   = 1'b0;
		wr_bank = home_q;
		wr_addr = count_q[AW-1:0];
		wr_data = in_rec;
		rd_addr = AW'(in_index);
		case (state_q)
			ST_IDLE: begin
				wr_en = accept && (in_cmd == CMD_APPEND) && !full;
			end
			ST_FL:    rd_addr = l_q[AW-1:0];
			ST_FR:    rd_addr = r_q[AW-1:0];
			ST_MERGE: begin
				wr_en   = l_has || r_has;
				wr_bank = !src_q;
				wr_addr = o_q[AW-1:0];
				wr_data = take_r ? right_q : left_q;
			end
			ST_RD0:   rd_addr = '0;
			ST_RLOOP: begin
				rd_addr = i_q[AW-1:0];
				wr_en   = (i_q >= count_q);
				wr_bank = src_q;
				wr_addr = k_q[AW-1:0];
				wr_data = acc_q;
			end
			ST_RW: begin
				wr_en   = !key_eq;
				wr_bank = src_q;
				wr_addr = k_q[AW-1:0];
				wr_data = acc_q;
			end
			default: ;
		endcase
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			home_q   <= 1'b0;
			src_q    <= 1'b0;
			both_q   <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			// the finish state loads the output register itself
			if (m_tready && state_q != ST_FIN) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_rec_q    <= '0;
						res_status_q <= STATUS_OK;
						state_q      <= ST_FIN;
						case (in_cmd)
							CMD_APPEND: begin
								if (full) begin
									res_status_q <= STATUS_FULL;
								end else begin
									count_q <= count_q + 1'b1;
								end
							end
							CMD_COALESCE: begin
								src_q <= home_q;
								w_q   <= PW'(1);
								lo_q  <= '0;
								if (count_q == CW'(1)) begin
									state_q <= ST_RD0;
								end else if (count_q != '0) begin
									state_q <= ST_BLK;
								end
							end
							CMD_READ: begin
								if (out_rng) begin
									res_status_q <= STATUS_RANGE;
								end else begin
									state_q <= ST_RWAIT;
								end
							end
							CMD_CLEAR: count_q <= '0;
							default: ;
						endcase
					end
				end
				ST_RWAIT: begin
					res_rec_q <= rd_data;
					state_q   <= ST_FIN;
				end
				ST_BLK: begin
					mid_q   <= blk_m;
					hi_q    <= blk_h;
					l_q     <= lo_q;
					r_q     <= blk_m;
					o_q     <= lo_q;
					both_q  <= 1'b1;
					state_q <= ST_FL;
				end
				ST_FL: begin
					if (l_has) begin
						state_q <= ST_FLW;
					end else begin
						state_q <= both_q ? ST_FR : ST_MERGE;
					end
				end
				ST_FLW: begin
					left_q  <= rd_data;
					state_q <= both_q ? ST_FR : ST_MERGE;
				end
				ST_FR: begin
					both_q  <= 1'b0;
					state_q <= r_has ? ST_FRW : ST_MERGE;
				end
				ST_FRW: begin
					right_q <= rd_data;
					state_q <= ST_MERGE;
				end
				ST_MERGE: begin
					if (!l_has && !r_has) begin
						if (nxt_lo < n_p) begin
							lo_q    <= nxt_lo;
							state_q <= ST_BLK;
						end else begin
							src_q <= !src_q;
							lo_q  <= '0;
							w_q   <= w_q << 1;
							state_q <= ((w_q << 1) < n_p) ? ST_BLK : ST_RD0;
						end
					end else begin
						o_q <= o_q + 1'b1;
						if (take_r) begin
							r_q     <= r_q + 1'b1;
							state_q <= ST_FR;
						end else begin
							l_q     <= l_q + 1'b1;
							state_q <= ST_FL;
						end
					end
				end
				ST_RD0: state_q <= ST_RD0W;
				ST_RD0W: begin
					acc_q   <= rd_data;
					i_q     <= CW'(1);
					k_q     <= '0;
					state_q <= ST_RLOOP;
				end
				ST_RLOOP: begin
					if (i_q < count_q) begin
						state_q <= ST_RW;
					end else begin
						// last run written this cycle
						count_q <= k_q + 1'b1;
						home_q  <= src_q;
						state_q <= ST_FIN;
					end
				end
				ST_RW: begin
					if (key_eq) begin
						acc_q <= merge_rec(acc_q, rd_data);
					end else begin
						acc_q <= rd_data;
						k_q   <= k_q + 1'b1;
					end
					i_q     <= i_q + 1'b1;
					state_q <= ST_RLOOP;
				end
				ST_FIN: begin
					if (slot_free) begin
						m_tvalid <= 1'b1;
						m_tuser  <= res_status_q;
						m_tdata  <= {3'd0, res_rec_q.edit, res_rec_q.samples,
							res_rec_q.strand, res_rec_q.secondary, res_rec_q.uniq,
							res_rec_q.support, res_rec_q.end_pos, res_rec_q.start_pos,
							res_rec_q.chrom, 11'(count_q)};
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/irsc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irsc_checker: port level checks of the junction record table
// watches the stream ports, bound to the top level
// ----------------------------------------------------------------------------
module irsc_checker #(
	parameter int TABLE_DEPTH = 1024
) (
	input wire         clk,
	input wire         arst_n,
	input wire         s_tvalid,
	input wire         s_tready,
	input wire         m_tvalid,
	input wire         m_tready,
	input wire [199:0] m_tdata,
	input wire [1:0]   m_tuser
);
	import irsc_pkg::*;

	// one word at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready stayed high after accept");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == STATUS_OK || m_tuser == STATUS_FULL
			|| m_tuser == STATUS_RANGE))
		else $error("bad status code");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STATUS_FULL |-> m_tdata[10:0] == 11'(TABLE_DEPTH))
		else $error("full status with table not full");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STATUS_RANGE |-> m_tdata[199:11] == '0)
		else $error("out of range read returned data");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind interval_record_sort_coalesce irsc_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_irsc_chk (.*);
`default_nettype wire

// File: test/interval_record_sort_coalesce_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_record_sort_coalesce_test: self-checking bench for the record table
// drives append, coalesce, read and clear words and checks every result word
// against an in-bench model of the stable sort and merge of equal keys
// ----------------------------------------------------------------------------
module interval_record_sort_coalesce_test;
	import irsc_pkg::*;

	localparam int DEPTH = 1024;

	typedef struct {
		status_t    st;
		logic [10:0] cnt;
		rec_t       r;
	} answer_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [199:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [199:0] m_tdata;
	logic [1:0]   m_tuser;

	interval_record_sort_coalesce #(.TABLE_DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// bench copy of the table and the answers still owed by the block
	rec_t    shadow_table[$];
	answer_t pending_answers[$];
	int      mismatches = 0;
	int      words_sent = 0;
	bit      quiet = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog
	initial begin
		#30_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic logic [71:0] sort_key(input rec_t r);
		sort_key = {r.chrom, r.start_pos, r.end_pos};
	endfunction

	function automatic logic [31:0] clip_sum(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] top);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		clip_sum = (s > {1'b0, top}) ? top : s[31:0];
	endfunction

	// stable insertion sort, then fold runs of equal keys into their first record
	task automatic coalesce_shadow();
		rec_t sorted[$];
		rec_t folded[$];
		rec_t x;
		int   j;
		foreach (shadow_table[i]) begin
			x = shadow_table[i];
			j = sorted.size();
			while (j > 0 && sort_key(sorted[j-1]) > sort_key(x)) j--;
			sorted.insert(j, x);
		end
		foreach (sorted[i]) begin
			x = sorted[i];
			if (folded.size() > 0 && sort_key(folded[$]) == sort_key(x)) begin
				folded[$].support   = clip_sum(folded[$].support, x.support, 32'hFFFF_FFFF);
				folded[$].uniq      = 24'(clip_sum(32'(folded[$].uniq), 32'(x.uniq),
					32'hFF_FFFF));
				folded[$].secondary = 24'(clip_sum(32'(folded[$].secondary), 32'(x.secondary),
					32'hFF_FFFF));
				folded[$].samples   = 16'(clip_sum(32'(folded[$].samples), 32'(x.samples),
					32'hFFFF));
				// unknown strand is resolved by the later record
				if (folded[$].strand == STRAND_UNKNOWN) folded[$].strand = x.strand;
			end else begin
				folded.insert(folded.size(), x);
			end
		end
		shadow_table = folded;
	endtask

	task automatic table_step(input cmd_t c, input rec_t r, input logic [9:0] idx,
			output answer_t a);
		a.st = STATUS_OK;
		a.r = '0;
		case (c)
			CMD_APPEND: begin
				if (shadow_table.size() >= DEPTH) a.st = STATUS_FULL;
				else shadow_table.insert(shadow_table.size(), r);
			end
			CMD_COALESCE: coalesce_shadow();
			CMD_READ: begin
				if (idx < shadow_table.size()) a.r = shadow_table[idx];
				else a.st = STATUS_RANGE;
			end
			default: shadow_table.delete();
		endcase
		a.cnt = 11'(shadow_table.size());
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// one word into the block; fixed answers override the bench model status and count
	task automatic send(input cmd_t c, input rec_t r, input logic [9:0] idx,
			input bit fixed = 1'b0, input status_t fst = STATUS_OK,
			input logic [10:0] fcnt = 11'd0);
		answer_t a;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			@(negedge clk) s_tvalid = 1'b0;
			repeat ($urandom_range(0, 2)) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = c;
		s_tdata = {4'b0, idx, r.edit, r.samples, r.strand, r.secondary, r.uniq, r.support,
			r.end_pos, r.start_pos, r.chrom};
		do @(posedge clk); while (!s_tready);
		table_step(c, r, idx, a);
		if (fixed) begin
			a.st = fst;
			a.cnt = fcnt;
		end
		pending_answers.insert(pending_answers.size(), a);
		words_sent++;
	endtask

	task automatic drain();
		@(negedge clk) s_tvalid = 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
	endtask

	// mostly a narrow key pool so equal keys are common, sometimes anything
	function automatic rec_t rand_rec();
		rec_t r;
		r.support   = $urandom;
		r.uniq      = 24'($urandom);
		r.secondary = 24'($urandom);
		r.samples   = 16'($urandom);
		r.edit      = 16'($urandom);
		r.strand    = 2'($urandom_range(0, 3));
		if ($urandom_range(0, 4) == 0) begin
			r.chrom = 10'($urandom);
			r.start_pos = 31'($urandom);
			r.end_pos = 31'($urandom);
		end else begin
			r.chrom = ($urandom_range(0, 5) == 0) ? 10'h3FF : 10'($urandom_range(0, 2));
			r.start_pos = ($urandom_range(0, 5) == 0) ? 31'h7FFF_FFFF : 31'($urandom_range(0, 2));
			r.end_pos = ($urandom_range(0, 5) == 0) ? 31'h7FFF_FFFF : 31'($urandom_range(0, 2));
			if ($urandom_range(0, 1) == 0) r.strand = STRAND_UNKNOWN;
		end
		return r;
	endfunction

	// result side: random stall bursts, none once the run goes quiet
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 4) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(0, 2)) @(negedge clk);
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		answer_t w;
		rec_t    g;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_answers.size() == 0) begin
				report("unexpected word", 32'(m_tuser), 32'd0);
			end else begin
				w = pending_answers.pop_front();
				g.chrom     = m_tdata[20:11];
				g.start_pos = m_tdata[51:21];
				g.end_pos   = m_tdata[82:52];
				g.support   = m_tdata[114:83];
				g.uniq      = m_tdata[138:115];
				g.secondary = m_tdata[162:139];
				g.strand    = m_tdata[164:163];
				g.samples   = m_tdata[180:165];
				g.edit      = m_tdata[196:181];
				if (m_tuser !== w.st) report("status", m_tuser, w.st);
				if (m_tdata[10:0] !== w.cnt) report("entry_count", m_tdata[10:0], w.cnt);
				if (g.chrom !== w.r.chrom) report("chrom", g.chrom, w.r.chrom);
				if (g.start_pos !== w.r.start_pos) report("start", g.start_pos, w.r.start_pos);
				if (g.end_pos !== w.r.end_pos) report("end", g.end_pos, w.r.end_pos);
				if (g.support !== w.r.support) report("support", g.support, w.r.support);
				if (g.uniq !== w.r.uniq) report("unique", g.uniq, w.r.uniq);
				if (g.secondary !== w.r.secondary) report("secondary", g.secondary, w.r.secondary);
				if (g.strand !== w.r.strand) report("strand", g.strand, w.r.strand);
				if (g.samples !== w.r.samples) report("samples", g.samples, w.r.samples);
				if (g.edit !== w.r.edit) report("edit", g.edit, w.r.edit);
			end
		end
	end

	typedef struct {
		cmd_t        c;
		rec_t        r;
		logic [9:0]  idx;
		bit          fixed;
		status_t     st;
		logic [10:0] cnt;
	} row_t;

	initial begin
		row_t rows[$];
		rec_t ones;
		rec_t zeros;
		rec_t r;
		int   n;
		ones = '1;
		zeros = '0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_APPEND;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// directed words: empty table, extremes, merge rules, range errors
		rows.insert(rows.size(), row_t'{CMD_READ, zeros, 10'd0, 1'b1, STATUS_RANGE, 11'd0});
		rows.insert(rows.size(), row_t'{CMD_COALESCE, zeros, 10'd0, 1'b1, STATUS_OK, 11'd0});
		rows.insert(rows.size(), row_t'{CMD_APPEND, ones, 10'd0, 1'b1, STATUS_OK, 11'd1});
		rows.insert(rows.size(), row_t'{CMD_APPEND, zeros, 10'd0, 1'b1, STATUS_OK, 11'd2});
		r = ones;
		r.strand = STRAND_UNKNOWN;
		r.edit = 16'h1234;
		// same key as all ones, strand 3 must survive, sums saturate
		rows.insert(rows.size(), row_t'{CMD_APPEND, r, 10'd0, 1'b1, STATUS_OK, 11'd3});
		r = zeros;
		r.strand = STRAND_UNKNOWN;
		r.support = 32'h0000_0180;
		r.edit = 16'd7;
		rows.insert(rows.size(), row_t'{CMD_APPEND, r, 10'd0, 1'b1, STATUS_OK, 11'd4});
		r.strand = 2'd1;
		r.edit = 16'd9;
		rows.insert(rows.size(), row_t'{CMD_APPEND, r, 10'd0, 1'b1, STATUS_OK, 11'd5});
		r = rand_rec();
		rows.insert(rows.size(), row_t'{CMD_APPEND, r, 10'd0, 1'b1, STATUS_OK, 11'd6});
		rows.insert(rows.size(), row_t'{CMD_READ, zeros, 10'h3FF, 1'b1, STATUS_RANGE, 11'd6});
		rows.insert(rows.size(), row_t'{CMD_READ, zeros, 10'd2, 1'b0, STATUS_OK, 11'd0});
		rows.insert(rows.size(), row_t'{CMD_COALESCE, zeros, 10'd0, 1'b0, STATUS_OK, 11'd0});
		for (int i = 0; i < 5; i++)
			rows.insert(rows.size(), row_t'{CMD_READ, zeros, 10'(i), 1'b0, STATUS_OK, 11'd0});
		rows.insert(rows.size(), row_t'{CMD_CLEAR, zeros, 10'd0, 1'b1, STATUS_OK, 11'd0});
		rows.insert(rows.size(), row_t'{CMD_READ, zeros, 10'd0, 1'b1, STATUS_RANGE, 11'd0});
		foreach (rows[i]) send(rows[i].c, rows[i].r, rows[i].idx, rows[i].fixed, rows[i].st,
			rows[i].cnt);

		// sender holds off until the block has answered everything
		drain();

		// full table: overflow append, last entry, one large coalesce
		for (int i = 0; i < DEPTH; i++) send(CMD_APPEND, rand_rec(), 10'd0);
		send(CMD_APPEND, rand_rec(), 10'd0, 1'b1, STATUS_FULL, 11'd1024);
		send(CMD_READ, zeros, 10'h3FF);
		send(CMD_COALESCE, zeros, 10'd0);
		for (int i = 0; i < 4; i++) send(CMD_READ, zeros, 10'($urandom_range(0, 7)));
		send(CMD_CLEAR, zeros, 10'd0);

		// random sessions: small batches of appends, coalesce, read back
		while (words_sent < 1800) begin
			if (words_sent > 1650) quiet = 1;
			if (shadow_table.size() > 30 || $urandom_range(0, 5) == 0)
				send(CMD_CLEAR, rand_rec(), 10'($urandom));
			n = $urandom_range(0, 10);
			for (int i = 0; i < n; i++) send(CMD_APPEND, rand_rec(), 10'($urandom));
			if ($urandom_range(0, 3) == 0) send(cmd_t'($urandom_range(0, 3)), rand_rec(),
				10'($urandom));
			if ($urandom_range(0, 4) != 0) send(CMD_COALESCE, rand_rec(), 10'($urandom));
			n = $urandom_range(0, 5);
			for (int i = 0; i < n; i++)
				send(CMD_READ, rand_rec(), ($urandom_range(0, 5) == 0) ? 10'($urandom) :
					10'($urandom_range(0, shadow_table.size() + 1)));
		end

		drain();
		repeat (50) @(posedge clk);
		if (mismatches == 0 && pending_answers.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
